### sv/sorted_table_binary_search_macros.svh
// ----------------------------------------------------------------------------
// Sorted table binary search - assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search - package
// Default sizes and command codes shared by the block's modules.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int STBS_TABLE_DEPTH = 256;
  localparam int STBS_ENTRY_WIDTH = 32;

  localparam int STBS_COUNT_W = 9;
  localparam int STBS_INDEX_W = 8;
  localparam int STBS_VALUE_W = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } stbs_cmd_t;

endpackage

### sv/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted table binary search - top level
// Loads a table of signed entries and runs binary search for keys over it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per command. in_tuser selects load or search;
//           in_tdata carries the entry index and the value (data or key).
//   out_* : one transfer per search, none per load. out_tuser is the found
//           flag, out_tdata the matching index (0 when not found).
//   cfg_* : writes entry_count, the number of entries searched. The user must
//           write it only while the block is idle; the block does not enforce
//           this. cfg_ready is always high.
// Operation:
//   A load writes its entry into the table as it is accepted. A search repeats
//   a probe step (bound check and registered table read) and a compare step
//   (compare and bound update) until a match or an empty range, then hands the
//   result off. The table has a single read port; one command is in flight at
//   a time and in_tready is low during a search.
// Reset: synchronous, active low; clears entry_count, the output valid and the sequencer.
//   Table contents are not cleared and must be loaded before searching.
// Stall: a finished search result waits in its own state while the output
//   register is occupied; in_tready stays low until the result has moved on.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::STBS_TABLE_DEPTH,
  parameter int ENTRY_WIDTH = stbs_pkg::STBS_ENTRY_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] entry_index, [39:8] value
  input  logic        in_tuser,   // [0] command
  // Search result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] position
  output logic        out_tuser,  // [0] found
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // [8:0] entry_count
);

  import stbs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_RESULT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [STBS_COUNT_W-1:0]       entry_count_r;
  logic [CNT_W-1:0]              lo_r, lo_nxt;
  logic [CNT_W-1:0]              hi_ex_r, hi_ex_nxt;   // upper bound plus one
  logic [CNT_W-1:0]              mid_r, mid_nxt;
  logic signed [ENTRY_WIDTH-1:0] key_r, key_nxt;
  logic                          found_r, found_nxt;
  logic [STBS_INDEX_W-1:0]       pos_r, pos_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [STBS_INDEX_W-1:0]       out_pos_r, out_pos_nxt;

  logic [STBS_INDEX_W-1:0]       in_entry_index;
  logic [STBS_VALUE_W-1:0]       in_value;
  stbs_cmd_t                     in_command;
  logic signed [63:0]            value_ext;
  logic signed [ENTRY_WIDTH-1:0] in_entry;
  logic                          in_xfer;
  logic [CNT_W-1:0]              cnt_sat;
  logic [CNT_W:0]                mid_sum;
  logic                          tbl_wr_en;
  logic                          tbl_rd_en;
  logic signed [ENTRY_WIDTH-1:0] tbl_rd_data;
  logic                          out_free;

  assign in_entry_index = in_tdata[7:0];
  assign in_value       = in_tdata[39:8];
  assign in_command     = stbs_cmd_t'(in_tuser);
  assign value_ext      = 64'(signed'(in_value));
  assign in_entry       = value_ext[ENTRY_WIDTH-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      cnt_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      cnt_sat = CNT_W'(entry_count_r);
    end
  end

  // Truncated average of lo and hi, with hi = hi_ex - 1
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_ex_r} - {{CNT_W{1'b0}}, 1'b1};

  assign tbl_wr_en = in_xfer && (in_command == CMD_LOAD) &&
                     (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign tbl_rd_en = (state_r == S_PROBE) && (lo_r < hi_ex_r);

  stbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (ADDR_W'(in_entry_index)),
    .wr_data (in_entry),
    .rd_en   (tbl_rd_en),
    .rd_addr (mid_sum[ADDR_W:1]),
    .rd_data (tbl_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_ex_nxt      = hi_ex_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_command == CMD_SEARCH)) begin
          lo_nxt    = '0;
          hi_ex_nxt = cnt_sat;
          key_nxt   = in_entry;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_ex_r) begin
          mid_nxt   = mid_sum[CNT_W:1];
          state_nxt = S_CMP;
        end else begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = S_RESULT;
        end
      end
      S_CMP: begin
        if (tbl_rd_data == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = STBS_INDEX_W'(mid_r);
          state_nxt = S_RESULT;
        end else begin
          // Narrow towards the key
          if (tbl_rd_data < key_r) begin
            lo_nxt = mid_r + CNT_W'(1);
          end else begin
            hi_ex_nxt = mid_r;
          end
          state_nxt = S_PROBE;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = found_r;
          out_pos_nxt    = pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
    end
    lo_r        <= lo_nxt;
    hi_ex_r     <= hi_ex_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_pos_r;

  `STBS_ASSERT_NOW(a_bounds_ordered, clk, rst_n,
    (state_r == S_PROBE) || (state_r == S_CMP),
    (lo_r <= hi_ex_r) && (hi_ex_r <= cnt_sat), "search bounds out of order")

  `STBS_ASSERT_NOW(a_miss_position_zero, clk, rst_n,
    out_tvalid_r && !out_found_r, out_pos_r == '0, "miss result with nonzero position")

  `STBS_ASSERT_NEXT(a_result_held, clk, rst_n,
    (state_r == S_RESULT) && out_tvalid_r && !out_tready,
    (state_r == S_RESULT) && out_tvalid_r, "pending search result dropped under stall")

  `STBS_ASSERT_NEXT(a_probe_in_range, clk, rst_n,
    (state_r == S_PROBE) && (lo_r < hi_ex_r),
    (state_r == S_CMP) && (mid_r < hi_ex_r) && (mid_r >= lo_r), "probe outside bounds")

endmodule

### sv/stbs_table.sv
// ----------------------------------------------------------------------------
// Sorted table binary search - entry table
// Single-port write, registered read table of signed entries.
// ----------------------------------------------------------------------------
module stbs_table #(
  parameter int TABLE_DEPTH = stbs_pkg::STBS_TABLE_DEPTH,
  parameter int ENTRY_WIDTH = stbs_pkg::STBS_ENTRY_WIDTH,
  parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  logic [ENTRY_WIDTH-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output logic [ENTRY_WIDTH-1:0] rd_data
);

  import stbs_pkg::*;

  logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
